/* hw/rtl/fcm_pkg.sv */
// Shared types, constants and functions for the frame-format-A CRC and
// Manchester transmit framer. No dependencies.
`timescale 1ns / 1ps

package fcm_pkg;

	// Block lengths in bytes (each from 1 to 16)
	localparam int unsigned FILL_W = 5;
	localparam logic [FILL_W-1:0] FIRST_BLOCK_LEN = FILL_W'(10);
	localparam logic [FILL_W-1:0] BLOCK_LEN       = FILL_W'(16);

	localparam logic [15:0] CRC_POLY = 16'h3D65;

	localparam logic [7:0] POST_ONE  = 8'h55;
	localparam logic [7:0] POST_ZERO = 8'hAA;

	localparam logic [1:0] CHIPS_ONE  = 2'b01;
	localparam logic [1:0] CHIPS_ZERO = 2'b10;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Beat index within one command
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_DATA_HI = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DATA_LO = 3'd1;
	localparam logic [STEP_W-1:0] STEP_CRC_HH  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_CRC_HL  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CRC_LH  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_CRC_LL  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_POST    = 3'd6;

	// What the back end emits for one input byte
	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,  // data byte only
		CMD_CRC  = 2'd1,  // data byte, then block CRC
		CMD_POST = 2'd2   // data byte, block CRC, postamble
	} fcm_cmd_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] crc;   // already complemented
		fcm_cmd_t    cmd;
	} fcm_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fcm_q_stat_t;

	// CRC-16 update over one byte, MSB first
	function automatic logic [15:0] fcm_crc_byte(input logic [15:0] crc, input logic [7:0] v);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ v[i];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// Manchester code one nibble, MSB first
	function automatic logic [7:0] fcm_manch(input logic [3:0] nib);
		logic [7:0] o;
		for (int i = 0; i < 4; i++) begin
			o[2*i +: 2] = nib[i] ? CHIPS_ONE : CHIPS_ZERO;
		end
		return o;
	endfunction

endpackage

/* hw/rtl/fcm_front.sv */
// Front end: takes frame bytes, runs the block CRC and fill count, and
// classifies each byte into a command for the queue. Uses fcm_pkg.
`timescale 1ns / 1ps

module fcm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_byte,
	input  logic                frame_end,
	input  fcm_pkg::fcm_q_stat_t q_stat,
	output logic                push,
	output fcm_pkg::fcm_entry_t push_entry
);
	import fcm_pkg::*;

	logic [15:0]       crc_q;
	logic [FILL_W-1:0] fill_q;
	logic              first_q;

	logic [15:0]       crc_next;
	logic [FILL_W-1:0] fill_next;
	logic [FILL_W-1:0] limit;
	logic              close;

	assign in_stall = q_stat.full;
	assign push     = in_valid & ~q_stat.full;

	always_comb begin
		crc_next  = fcm_crc_byte(crc_q, in_byte);
		fill_next = fill_q + FILL_W'(1);
		limit     = first_q ? FIRST_BLOCK_LEN : BLOCK_LEN;
		close     = (fill_next >= limit) || frame_end;

		push_entry.data = in_byte;
		push_entry.crc  = ~crc_next;
		if (frame_end) begin
			push_entry.cmd = CMD_POST;
		end else if (close) begin
			push_entry.cmd = CMD_CRC;
		end else begin
			push_entry.cmd = CMD_DATA;
		end
	end

	// Restart the block on close; a frame end also returns to the first block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			fill_q  <= '0;
			first_q <= 1'b1;
		end else if (push) begin
			if (close) begin
				crc_q   <= '0;
				fill_q  <= '0;
				first_q <= frame_end;
			end else begin
				crc_q  <= crc_next;
				fill_q <= fill_next;
			end
		end
	end

endmodule

/* hw/rtl/fcm_queue.sv */
// Short command queue between front and back end, held in registers.
// Uses fcm_pkg for the entry and status types.
`timescale 1ns / 1ps

module fcm_queue #(
	parameter int unsigned DEPTH = fcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fcm_pkg::fcm_entry_t  push_entry,
	input  logic                 pop,
	output fcm_pkg::fcm_entry_t  head,
	output fcm_pkg::fcm_q_stat_t q_stat
);
	import fcm_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	fcm_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/fcm_back.sv */
// Back end: walks the queue head beat by beat, Manchester codes each nibble
// and holds the result in the output register. Uses fcm_pkg.
`timescale 1ns / 1ps

module fcm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcm_pkg::fcm_entry_t  head,
	input  fcm_pkg::fcm_q_stat_t q_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 run_end
);
	import fcm_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              end_q;

	logic              adv;
	logic              take;
	logic [STEP_W-1:0] last_step;
	logic              is_last;
	logic [7:0]        beat;

	assign adv  = ~valid_q | ~out_stall;
	assign take = adv & ~q_stat.empty;

	always_comb begin
		unique case (head.cmd)
			CMD_DATA: last_step = STEP_DATA_LO;
			CMD_CRC:  last_step = STEP_CRC_LL;
			CMD_POST: last_step = STEP_POST;
			default:  last_step = STEP_DATA_LO;
		endcase
		is_last = (step_q == last_step);
		pop     = take & is_last;

		unique case (step_q)
			STEP_DATA_HI: beat = fcm_manch(head.data[7:4]);
			STEP_DATA_LO: beat = fcm_manch(head.data[3:0]);
			STEP_CRC_HH:  beat = fcm_manch(head.crc[15:12]);
			STEP_CRC_HL:  beat = fcm_manch(head.crc[11:8]);
			STEP_CRC_LH:  beat = fcm_manch(head.crc[7:4]);
			STEP_CRC_LL:  beat = fcm_manch(head.crc[3:0]);
			STEP_POST:    beat = head.crc[0] ? POST_ONE : POST_ZERO;
			default:      beat = POST_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_DATA_HI;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ~q_stat.empty;
			if (take) begin
				step_q <= is_last ? STEP_DATA_HI : step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= beat;
			end_q  <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_end   = end_q;

endmodule

/* hw/rtl/format_a_crc_manchester_tx.sv */
// Top level of the frame-format-A CRC and Manchester transmit framer.
// Instantiates fcm_front, fcm_queue and fcm_back; uses fcm_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------
//   in      | into      | in_valid / in_stall    | in_byte, frame_end
//   out     | out of    | out_valid / out_stall  | out_byte, run_end
//
// One input beat gives 2 output beats (plain data byte), 6 (data byte that
// closes a block: data plus CRC) or 7 (frame end: data, CRC, postamble).
// The back end sends one output beat a cycle while out_stall is low, and the
// output port sets the sustained rate. The first output beat of a byte is
// registered in the queue entry and then in the output register.
// Reset clears the CRC, block fill, queue pointers, beat index and output
// valid and sets the first-block flag; the framer waits for the first byte.
// in_stall rises only while the command queue is full; out_stall freezes the
// output register and back end while the front keeps filling the queue.
`timescale 1ns / 1ps

module format_a_crc_manchester_tx #(
	parameter int unsigned QUEUE_DEPTH = fcm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end
);
	import fcm_pkg::*;

	fcm_q_stat_t q_stat;
	fcm_entry_t  push_entry;
	fcm_entry_t  head;
	logic        push;
	logic        pop;

	// Front: classify each byte, advance CRC and fill, push one command
	fcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.frame_end  (frame_end),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue: decouple front and back so each can stall on its own
	fcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back: emit the coded beats of the head command, drop it on its last beat
	fcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

endmodule

/* hw/rtl/fcm_checker.sv */
// Port-level checker for the framer, bound to the top level.
// Needs only the top-level ports.
`timescale 1ns / 1ps

module fcm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       frame_end,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_end
);
	logic [7:0] pending_q;
	logic       in_acc;
	logic       run_done;

	assign in_acc   = in_valid & ~in_stall;
	assign run_done = out_valid & ~out_stall & run_end;

	// Count input beats whose output run is not yet finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !run_done) begin
			pending_q <= pending_q + 8'd1;
		end else if (run_done && !in_acc) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(run_end))
		else $error("stalled output beat changed");

	a_chip_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_byte[7] != out_byte[6]) && (out_byte[5] != out_byte[4]) &&
			(out_byte[3] != out_byte[2]) && (out_byte[1] != out_byte[0]))
		else $error("output beat is not Manchester coded");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("output beat without a pending input");

endmodule

bind format_a_crc_manchester_tx fcm_checker u_fcm_checker (.*);

/* bench/tb.sv */
// Self-checking bench for the frame-format-A CRC and Manchester transmit framer.
// Depends on fcm_pkg and format_a_crc_manchester_tx; keeps its own frame model.
`timescale 1ns / 1ps

module tb;
	import fcm_pkg::*;

	localparam int unsigned HALF_PERIOD = 10;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned PHASE_ITEMS = 110;

	// One output beat as the framer should send it
	typedef struct packed {
		logic [7:0] chips;
		logic       run_end;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       frame_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;

	// Frame model state: running block CRC, bytes in the block, first-block flag
	logic [15:0]       blk_crc = '0;
	logic [FILL_W-1:0] blk_fill = '0;
	logic              first_blk = 1'b1;

	beat_t coded_q[$];

	int unsigned send_pct = 0;
	int unsigned recv_pct = 0;
	bit          hold_go = 1'b0;
	int unsigned mismatches = 0;
	int unsigned n_items = 0;
	int unsigned n_beats = 0;
	int unsigned n_frames = 0;
	int unsigned n_in_stall = 0;
	int unsigned quiet_cycles = 0;

	format_a_crc_manchester_tx DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// CRC-16 over one byte, MSB first, no reflection
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		logic [7:0]  v;
		logic        fb;
		r = acc;
		v = d;
		repeat (8) begin
			fb = r[15] ^ v[7];
			r  = r << 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
			v = v << 1;
		end
		return r;
	endfunction

	// Four bits to eight chips, first bit in the top chip pair
	function automatic logic [7:0] manch_code(input logic [3:0] nib);
		logic [7:0] o;
		o = '0;
		for (int i = 3; i >= 0; i--) begin
			o = {o[5:0], nib[i] ? CHIPS_ONE : CHIPS_ZERO};
		end
		return o;
	endfunction

	// Append one expected beat at the tail of the prediction queue
	function automatic void add_beat(input logic [7:0] chips);
		coded_q.insert(coded_q.size(), beat_t'{chips, 1'b0});
	endfunction

	// Work out the beats one input byte causes and queue them up
	function automatic void predict_frame_byte(input logic [7:0] b, input logic e);
		logic [FILL_W-1:0] lim;
		logic [FILL_W-1:0] nxt;
		logic [15:0]       sum;
		lim = first_blk ? FIRST_BLOCK_LEN : BLOCK_LEN;
		add_beat(manch_code(b[7:4]));
		add_beat(manch_code(b[3:0]));
		blk_crc = crc16_step(blk_crc, b);
		nxt = blk_fill + FILL_W'(1);
		if (nxt >= lim || e) begin
			// close the block: complemented CRC, high byte first
			sum = ~blk_crc;
			add_beat(manch_code(sum[15:12]));
			add_beat(manch_code(sum[11:8]));
			add_beat(manch_code(sum[7:4]));
			add_beat(manch_code(sum[3:0]));
			blk_crc = '0;
			blk_fill = '0;
			first_blk = 1'b0;
			if (e) begin
				// postamble follows the last chip, which is CRC bit 0
				add_beat(sum[0] ? POST_ONE : POST_ZERO);
				first_blk = 1'b1;
				n_frames++;
			end
		end else begin
			blk_fill = nxt;
		end
		coded_q[coded_q.size()-1].run_end = 1'b1;
	endfunction

	// Offer one byte; enter and leave at a falling edge, valid left high
	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(0, 99) < send_pct) begin
			// idle with junk on the payload
			in_valid  = 1'b0;
			in_byte   = 8'($urandom);
			frame_end = 1'($urandom);
			@(negedge clk);
		end
		in_valid  = 1'b1;
		in_byte   = b;
		frame_end = e;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_frame_byte(b, e);
		n_items++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted beat has come out
	task automatic drain;
		in_valid = 1'b0;
		while (coded_q.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Pick a single-byte frame whose postamble is the wanted one
	function automatic logic [7:0] byte_for_post(input logic want_one);
		logic [15:0] s;
		for (int b = 0; b < 256; b++) begin
			s = ~crc16_step(16'h0000, 8'(b));
			if (s[0] == want_one) begin
				return 8'(b);
			end
		end
		return 8'h00;
	endfunction

	// Extreme bytes, one-byte frames, both postambles, full first block at
	// frame end, and a first block closed by length followed by a short one
	task automatic test_directed;
		logic [7:0] pat[10];
		send_pct = 0;
		recv_pct = 0;
		pat = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h0F, 8'hF0};
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(byte_for_post(1'b1), 1'b1);
		send_byte(byte_for_post(1'b0), 1'b1);
		// block full and frame end on the same byte
		for (int i = 0; i < 10; i++) begin
			send_byte(pat[i], i == 9);
		end
		// first block closes by length, then a one-byte block ends the frame
		for (int i = 0; i < 11; i++) begin
			send_byte(pat[9 - (i % 10)] ^ 8'(i), i == 10);
		end
		drain();
	endtask

	// Whole frames of random content, lengths biased to block boundaries
	task automatic test_random_frames(input int unsigned n, input int unsigned s_pct,
			input int unsigned r_pct);
		int unsigned start;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  b;
		send_pct = s_pct;
		recv_pct = r_pct;
		start = n_items;
		while (n_items - start < n) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				len = FIRST_BLOCK_LEN + BLOCK_LEN * $urandom_range(0, 2);
				len = len + $urandom_range(0, 2) - 1;
			end else if (pick < 6) begin
				len = $urandom_range(1, 12);
			end else begin
				len = $urandom_range(1, 60);
			end
			for (int unsigned i = 0; i < len; i++) begin
				b = 8'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				send_byte(b, i == len - 1);
			end
		end
		drain();
	endtask

	// Hold the output off for a long stretch while bytes keep coming, so the
	// command queue fills and the framer stalls its input
	task automatic test_backpressure;
		send_pct = 0;
		recv_pct = 0;
		hold_go = ~hold_go;
		for (int i = 0; i < 20; i++) begin
			send_byte(8'($urandom), i == 19);
		end
		drain();
	endtask

	// Receiver: random stall, or a long hold when one is requested
	initial begin : receiver
		bit          hold_seen;
		int unsigned hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_pct);
			end
		end
	end

	// Compare each output beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_beats++;
			if (coded_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual out_byte %h run_end %b",
					$time, out_byte, run_end);
				mismatches++;
			end else begin
				if (out_byte !== coded_q[0].chips) begin
					$display("%0t: out_byte mismatch, expected %h, actual %h",
						$time, coded_q[0].chips, out_byte);
					mismatches++;
				end
				if (run_end !== coded_q[0].run_end) begin
					$display("%0t: run_end mismatch, expected %b, actual %b",
						$time, coded_q[0].run_end, run_end);
					mismatches++;
				end
				void'(coded_q.pop_front());
			end
		end
	end

	// Count input stall cycles, and cycles with no beat on either channel
	always @(posedge clk) begin
		if (in_valid && in_stall) begin
			n_in_stall++;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("%0t: no beat for %0d cycles, %0d beats still expected",
			$time, WATCHDOG_LIMIT, coded_q.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : main
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_frames(PHASE_ITEMS, 30, 84);
		test_random_frames(PHASE_ITEMS, 84, 30);
		test_random_frames(PHASE_ITEMS, 0, 0);
		test_backpressure();
		// let any late beat show before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d input bytes in %0d frames, %0d output beats checked,",
			n_items, n_frames, n_beats);
		$display("%0d input stall cycles, %0d mismatches", n_in_stall, mismatches);
		if (mismatches == 0 && coded_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/fcm_pkg.sv
hw/rtl/fcm_front.sv
hw/rtl/fcm_queue.sv
hw/rtl/fcm_back.sv
hw/rtl/format_a_crc_manchester_tx.sv
hw/rtl/fcm_checker.sv
bench/tb.sv
